// ----- rtl/core/sacl_pkg.sv -----
package sacl_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 64;

    localparam int ADDRESS_W      = 64;
    localparam int MODE_W         = 2;
    localparam int HIT_COUNT_W    = 2;
    localparam int SET_BITS_W     = 3;
    localparam int BLOCK_BITS_W   = 6;
    localparam int WAY_COUNT_W    = 4;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 6;
    localparam int MAX_BLOCK_BITS = 32;
    // block offset plus set index never exceeds 39
    localparam int SHIFT_W        = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_IFETCH = 2'd3
    } mode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAY_COUNT  = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear;
        logic update;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

// ----- rtl/core/sacl_ctrl.sv -----
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctl_cmd_t   cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CLEAR  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_capture_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.update)
        else $error("update did not follow capture");

    a_update_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> !busy)
        else $error("not idle after update");

    a_clear_runs_on: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear && !status.clear_last) |=> cmd.clear)
        else $error("clear pass cut short");

endmodule

// ----- rtl/core/sacl_datapath.sv -----
module sacl_datapath
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [MODE_W-1:0]      mode,
    input  logic [ADDRESS_W-1:0]   address,
    input  ctl_cmd_t               cmd,
    output dp_status_t             status,
    output logic                   done,
    output logic [HIT_COUNT_W-1:0] hit_count,
    output logic                   missed,
    output logic                   evicted
);

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_IDX_W = RANK_W;
    localparam int WAYS_W    = $clog2(MAX_WAYS + 1);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } meta_row_t;

    tag_row_t  tag_mem  [NUM_SETS];
    meta_row_t meta_mem [NUM_SETS];

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAY_COUNT_W-1:0]  way_count_reg;

    logic [SHIFT_W-1:0]    sb_eff;
    logic [SHIFT_W-1:0]    bb_eff;
    logic [SHIFT_W-1:0]    tag_shift;
    logic [WAYS_W-1:0]     ways_eff;
    logic [ADDR_WIDTH-1:0] addr_in;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [SET_IDX_W-1:0]  set_in;
    logic [ADDR_WIDTH-1:0] tag_in;

    logic [SET_IDX_W-1:0]  clr_ptr_reg;
    mode_t                 mode_reg;
    logic [SET_IDX_W-1:0]  set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    tag_row_t              tag_rd_reg;
    meta_row_t             meta_rd_reg;

    logic [MAX_WAYS-1:0]  act;
    logic [MAX_WAYS-1:0]  hit_vec;
    logic                 hit_any;
    logic                 empty_any;
    logic [WAY_IDX_W-1:0] hit_way;
    logic [WAY_IDX_W-1:0] empty_way;
    logic [WAY_IDX_W-1:0] vic_way;
    logic [RANK_W-1:0]    vic_rank;
    logic [RANK_W-1:0]    ref_rank;
    logic [WAY_IDX_W-1:0] tgt_way;
    meta_row_t            meta_new;
    tag_row_t             tag_new;
    logic                 is_ifetch;
    logic                 row_write;

    logic                   done_reg;
    logic [HIT_COUNT_W-1:0] hit_count_reg;
    logic                   missed_reg;
    logic                   evicted_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            way_count_reg  <= WAY_COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAY_COUNT:  way_count_reg  <= cfg_data[WAY_COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        sb_eff = (int'(set_bits_reg) > MAX_SET_BITS) ? SHIFT_W'(MAX_SET_BITS)
                                                      : SHIFT_W'(set_bits_reg);
        bb_eff = (int'(block_bits_reg) > MAX_BLOCK_BITS) ? SHIFT_W'(MAX_BLOCK_BITS)
                                                          : SHIFT_W'(block_bits_reg);
        priority if (way_count_reg == '0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (int'(way_count_reg) > MAX_WAYS)
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_W'(way_count_reg);
        end
        tag_shift = bb_eff + sb_eff;
    end

    // address split
    assign addr_in = address[ADDR_WIDTH-1:0];
    assign addr_sh = addr_in >> bb_eff;

    always_comb
    begin
        for (int i = 0; i < SET_IDX_W; i++)
        begin
            set_in[i] = addr_sh[i] & (SHIFT_W'(i) < sb_eff);
        end
        tag_in = (int'(tag_shift) >= ADDR_WIDTH) ? '0 : (addr_in >> tag_shift);
    end

    // reset clear pass over the line state, one set a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_ptr_reg == SET_IDX_W'(NUM_SETS - 1));

    // request capture and set read
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= mode_t'(mode);
            set_reg     <= set_in;
            tag_reg     <= tag_in;
            tag_rd_reg  <= tag_mem[set_in];
            meta_rd_reg <= meta_mem[set_in];
        end
    end

    // compare and replacement
    always_comb
    begin
        act       = '0;
        hit_vec   = '0;
        hit_way   = '0;
        empty_way = '0;
        empty_any = 1'b0;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            act[j]     = (WAYS_W'(j) < ways_eff);
            hit_vec[j] = act[j] & meta_rd_reg.valid[j] & (tag_rd_reg[j] == tag_reg);
        end
        // lowest hitting way wins
        for (int j = MAX_WAYS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_way = WAY_IDX_W'(j);
            end
        end
        // highest free way is filled
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if (act[j] && !meta_rd_reg.valid[j])
            begin
                empty_way = WAY_IDX_W'(j);
                empty_any = 1'b1;
            end
        end
        hit_any = |hit_vec;
    end

    // oldest way, ties to the highest; way 0 is always in use
    always_comb
    begin
        vic_way  = '0;
        vic_rank = meta_rd_reg.rank[0];
        for (int j = 1; j < MAX_WAYS; j++)
        begin
            if (act[j] && (meta_rd_reg.rank[j] >= vic_rank))
            begin
                vic_way  = WAY_IDX_W'(j);
                vic_rank = meta_rd_reg.rank[j];
            end
        end
    end

    always_comb
    begin
        logic bump;
        ref_rank = hit_any ? meta_rd_reg.rank[hit_way] : vic_rank;
        tgt_way  = hit_any ? hit_way : (empty_any ? empty_way : vic_way);
        meta_new = meta_rd_reg;
        tag_new  = tag_rd_reg;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            priority if (hit_any)
            begin
                bump = act[j] && (WAY_IDX_W'(j) != hit_way) && meta_rd_reg.valid[j]
                       && (meta_rd_reg.rank[j] < ref_rank);
            end
            else if (empty_any)
            begin
                bump = act[j] && meta_rd_reg.valid[j];
            end
            else
            begin
                bump = act[j] && (WAY_IDX_W'(j) != vic_way)
                       && (meta_rd_reg.rank[j] < ref_rank);
            end
            if (bump && (meta_rd_reg.rank[j] != RANK_MAX))
            begin
                meta_new.rank[j] = meta_rd_reg.rank[j] + 1'b1;
            end
        end
        meta_new.rank[tgt_way]  = '0;
        meta_new.valid[tgt_way] = 1'b1;
        if (!hit_any)
        begin
            tag_new[tgt_way] = tag_reg;
        end
    end

    assign is_ifetch = (mode_reg == MODE_IFETCH);
    assign row_write = cmd.update & !is_ifetch;

    // write back
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            meta_mem[clr_ptr_reg] <= '0;
        end
        else if (row_write)
        begin
            meta_mem[set_reg] <= meta_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_write)
        begin
            tag_mem[set_reg] <= tag_new;
        end
    end

    // result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_count_reg <= is_ifetch ? '0
                           : (HIT_COUNT_W'(hit_any) + HIT_COUNT_W'(mode_reg == MODE_MODIFY));
            missed_reg    <= !is_ifetch && !hit_any;
            evicted_reg   <= !is_ifetch && !hit_any && !empty_any;
        end
    end

    assign done      = done_reg;
    assign hit_count = hit_count_reg;
    assign missed    = missed_reg;
    assign evicted   = evicted_reg;

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> missed)
        else $error("eviction reported without a miss");

    a_miss_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (done && missed) |-> (hit_count != HIT_COUNT_W'(2)))
        else $error("miss reported with a lookup hit");

endmodule

// ----- rtl/core/set_assoc_cache_lru_lookup.sv -----
// Set-associative cache lookup with exact LRU replacement.
// Requests: drive mode and address with start high; a request is taken at a
// rising edge where start is high and busy is low. Each request gives one
// result: done is high for exactly one cycle with hit_count, missed and
// evicted valid in that cycle. The receiver cannot hold results off.
// Timing: a taken request has its set read at the taking edge, and compare and
// tag/rank write-back of the set in the following cycle, the update state;
// done is registered at the edge that ends that state, and busy is low again
// from that edge, so no new request is taken while one is open.
// Instruction fetches take the same steps, write nothing back and report zeros.
// Configuration: cfg_write with cfg_index (0 set bits, 1 block bits, 2 way
// count) and cfg_data, written at once; write only while no request is open.
// Reset: configuration returns to 0/0/1 and a clear pass sweeps the valid and
// rank store one set a cycle over all 2**MAX_SET_BITS sets (64 by default),
// with busy high throughout. Tags are not cleared.
module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [MODE_W-1:0]      mode,
    input  logic [ADDRESS_W-1:0]   address,
    output logic                   done,
    output logic [HIT_COUNT_W-1:0] hit_count,
    output logic                   missed,
    output logic                   evicted,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    sacl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sacl_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .address   (address),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .hit_count (hit_count),
        .missed    (missed),
        .evicted   (evicted)
    );

endmodule
